[rtl/u8seg_pkg.sv]
package u8seg_pkg;

  // Payload widths of the byte and character channels.
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CharBytesW = 48;
  localparam int unsigned LenW       = 3;

  typedef logic [ByteW-1:0]      byte_t;
  typedef logic [CharBytesW-1:0] char_bytes_t;
  typedef logic [LenW-1:0]       len_t;

  // Byte count since the last lead; it saturates at its all-ones value.
  localparam len_t CntSat = '1;

  // Prefix masks and patterns that classify a byte.
  localparam byte_t MaskTop   = 8'h80;
  localparam byte_t MaskCont  = 8'hC0;
  localparam byte_t PatCont   = 8'h80;
  localparam byte_t MaskLead2 = 8'hE0;
  localparam byte_t PatLead2  = 8'hC0;
  localparam byte_t MaskLead3 = 8'hF0;
  localparam byte_t PatLead3  = 8'hE0;
  localparam byte_t MaskLead4 = 8'hF8;
  localparam byte_t PatLead4  = 8'hF0;
  localparam byte_t MaskLead5 = 8'hFC;
  localparam byte_t PatLead5  = 8'hF8;
  localparam byte_t MaskLead6 = 8'hFE;
  localparam byte_t PatLead6  = 8'hFC;

  // Character length announced by a lead byte; zero for 0xFE and 0xFF.
  function automatic len_t lead_length(byte_t b);
    len_t len;
    len = '0;
    if ((b & MaskLead2) == PatLead2) begin
      len = 3'd2;
    end else if ((b & MaskLead3) == PatLead3) begin
      len = 3'd3;
    end else if ((b & MaskLead4) == PatLead4) begin
      len = 3'd4;
    end else if ((b & MaskLead5) == PatLead5) begin
      len = 3'd5;
    end else if ((b & MaskLead6) == PatLead6) begin
      len = 3'd6;
    end
    return len;
  endfunction

endpackage

[rtl/u8seg_in_if.sv]
interface u8seg_in_if;
  import u8seg_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  string_start;

  modport source (output valid, output data_byte, output string_start, input ready);
  modport sink (input valid, input data_byte, input string_start, output ready);

endinterface

[rtl/u8seg_out_if.sv]
interface u8seg_out_if;
  import u8seg_pkg::*;

  logic        valid;
  logic        ready;
  char_bytes_t char_bytes;
  len_t        char_len;

  modport source (output valid, output char_bytes, output char_len, input ready);
  modport sink (input valid, input char_bytes, input char_len, output ready);

endinterface

[rtl/utf8_character_segmenter_core.sv]
// A character beat is registered and presented in the cycle after the byte beat that completes it.
// Throughput: one byte per cycle; the single output register stalls the input only
// while a finished character waits and the sink holds ready low.
// Reset (rst_ni low, asynchronous): parse state clears to no pending character,
// and the output register is emptied.
module utf8_character_segmenter_core #(
  parameter int unsigned MaxSeqBytes = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8seg_in_if.sink    byte_i,
  u8seg_out_if.source char_o
);
  import u8seg_pkg::*;

  localparam int unsigned PartW  = MaxSeqBytes * ByteW;
  localparam len_t        MaxLen = LenW'(MaxSeqBytes);

  // Parse state.
  len_t             exp_len_q, exp_len_d;
  len_t             cnt_q, cnt_d;
  logic [PartW-1:0] part_q, part_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  char_bytes_t out_bytes_q, out_bytes_d;
  len_t        out_len_q, out_len_d;

  // Result of the current byte.
  logic        res_valid;
  char_bytes_t res_bytes;
  len_t        res_len;

  // State seen by this byte after an optional string restart.
  len_t             base_exp;
  len_t             base_cnt;
  logic [PartW-1:0] base_part;
  len_t             cnt_next;
  len_t             lead_len;
  byte_t            b;
  logic             in_acc;

  assign b      = byte_i.data_byte;
  assign in_acc = byte_i.valid && byte_i.ready;

  // Take a new byte unless a finished character is stuck in the output register.
  assign byte_i.ready = !out_valid_q || char_o.ready;

  // Classify the byte and work out the next parse state and any result.
  always_comb begin
    base_exp  = byte_i.string_start ? '0 : exp_len_q;
    base_cnt  = byte_i.string_start ? '0 : cnt_q;
    base_part = byte_i.string_start ? '0 : part_q;
    cnt_next  = (base_cnt == CntSat) ? CntSat : base_cnt + 3'd1;
    lead_len  = lead_length(b);

    exp_len_d = base_exp;
    cnt_d     = base_cnt;
    part_d    = base_part;
    res_valid = 1'b0;
    res_bytes = '0;
    res_len   = '0;

    if ((b & MaskTop) == '0) begin
      // ASCII: emit at once and drop any pending group.
      exp_len_d = '0;
      cnt_d     = 3'd1;
      part_d    = PartW'(b);
      res_valid = 1'b1;
      res_bytes = CharBytesW'(b);
      res_len   = 3'd1;
    end else if ((b & MaskCont) == PatCont) begin
      // Continuation: store it in its lane and complete the group on the last byte.
      cnt_d = cnt_next;
      for (int unsigned i = 0; i < MaxSeqBytes; i++) begin
        if (cnt_next == LenW'(i + 1)) begin
          part_d[i*ByteW +: ByteW] = base_part[i*ByteW +: ByteW] | b;
        end
      end
      if (base_exp != '0 && cnt_next == base_exp) begin
        res_valid = 1'b1;
        res_bytes = CharBytesW'(part_d);
        res_len   = cnt_next;
        exp_len_d = '0;
      end
    end else begin
      // Lead: restart the group; an unusable lead keeps the old length.
      if (lead_len != '0 && lead_len <= MaxLen) begin
        exp_len_d = lead_len;
      end
      cnt_d  = 3'd1;
      part_d = PartW'(b);
    end
  end

  // Output register: load on an accepted byte, empty when the sink takes the beat.
  always_comb begin
    out_valid_d = out_valid_q;
    out_bytes_d = out_bytes_q;
    out_len_d   = out_len_q;
    if (in_acc) begin
      out_valid_d = res_valid;
      out_bytes_d = res_bytes;
      out_len_d   = res_len;
    end else if (char_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q   <= '0;
      cnt_q       <= '0;
      part_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        exp_len_q <= exp_len_d;
        cnt_q     <= cnt_d;
        part_q    <= part_d;
      end
    end
  end

  // Payload register of the output beat.
  always_ff @(posedge clk_i) begin
    out_bytes_q <= out_bytes_d;
    out_len_q   <= out_len_d;
  end

  assign char_o.valid      = out_valid_q;
  assign char_o.char_bytes = out_bytes_q;
  assign char_o.char_len   = out_len_q;

`ifndef SYNTHESIS
  // A delivered character always has a legal length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_len_q >= 3'd1 && out_len_q <= MaxLen))
    else $error("character length out of range");

  // An accepted ASCII byte shows up as a one-byte character on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (b & MaskTop) == '0) |=>
      (out_valid_q && out_len_q == 3'd1 && out_bytes_q == CharBytesW'($past(b))))
    else $error("ASCII byte not emitted");

  // A pending length is never one and never beyond the longest character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_len_q != 3'd1 && exp_len_q <= MaxLen)
    else $error("expected length out of range");

  // A single-byte character carries zeros in its unused upper bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_len_q == 3'd1) |-> (out_bytes_q[CharBytesW-1:ByteW] == '0))
    else $error("single-byte character has upper bytes set");
`endif

endmodule

[bench/tb_utf8_character_segmenter_core.sv]
module tb_utf8_character_segmenter_core;
  import u8seg_pkg::*;

  localparam int MaxSeq       = 6;
  localparam int RandomItems  = 450;
  localparam int QuietItems   = 100;
  localparam int SettleCycles = 4;
  localparam int DrainLimit   = 2000;

  // One completed character as the core should present it.
  typedef struct {
    char_bytes_t bytes;
    len_t        len;
  } char_beat_t;

  logic clk_i;
  logic rst_ni;

  u8seg_in_if  byte_if ();
  u8seg_out_if char_if ();

  utf8_character_segmenter_core #(
    .MaxSeqBytes(MaxSeq)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .byte_i(byte_if),
    .char_o(char_if)
  );

  // Parse state of the segmenter as the bench tracks it.
  len_t        want_len   = '0;
  len_t        seen_cnt   = '0;
  char_bytes_t group_acc  = '0;
  char_beat_t  pending_chars[$];

  int errors       = 0;
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  int stall_left   = 0;

  always #1 clk_i = ~clk_i;

  // Number of leading ones in a byte; 2..6 marks a lead, 7 and 8 are 0xFE and 0xFF.
  function automatic int lead_run(byte_t b);
    int n;
    n = 0;
    for (int i = 7; i >= 0; i--) begin
      if (!b[i]) break;
      n++;
    end
    return n;
  endfunction

  // Append one finished character to the list of characters still to come.
  function automatic void queue_char(char_beat_t beat);
    pending_chars.insert(pending_chars.size(), beat);
  endfunction

  // Advance the tracked parse state by one byte and queue any finished character.
  function automatic void segment_byte(byte_t b, logic start);
    char_beat_t beat;
    int         run;
    if (start) begin
      want_len  = '0;
      seen_cnt  = '0;
      group_acc = '0;
    end
    if (!b[7]) begin
      want_len   = '0;
      seen_cnt   = len_t'(1);
      group_acc  = char_bytes_t'(b);
      beat.bytes = char_bytes_t'(b);
      beat.len   = len_t'(1);
      queue_char(beat);
    end else if (b[7:6] == 2'b10) begin
      if (seen_cnt != CntSat) begin
        seen_cnt = seen_cnt + len_t'(1);
      end
      if (seen_cnt <= len_t'(6)) begin
        group_acc[8*(int'(seen_cnt)-1) +: 8] = group_acc[8*(int'(seen_cnt)-1) +: 8] | b;
      end
      if (want_len != '0 && seen_cnt == want_len) begin
        beat.bytes = group_acc;
        beat.len   = seen_cnt;
        queue_char(beat);
        want_len = '0;
      end
    end else begin
      run = lead_run(b);
      if (run >= 2 && run <= MaxSeq) begin
        want_len = len_t'(run);
      end
      seen_cnt  = len_t'(1);
      group_acc = char_bytes_t'(b);
    end
  endfunction

  // Lead byte of an n-byte character with random payload bits.
  function automatic byte_t make_lead(int n);
    byte_t prefix;
    byte_t payload;
    prefix  = 8'hFF << (8 - n);
    payload = 8'hFF >> (n + 1);
    return prefix | (byte_t'($urandom) & payload);
  endfunction

  function automatic byte_t rand_cont();
    return 8'h80 | byte_t'($urandom_range(0, 63));
  endfunction

  // Track every byte beat the core takes.
  always @(posedge clk_i) begin : track_bytes
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      segment_byte(byte_if.data_byte, byte_if.string_start);
    end
  end

  // Compare every character beat with the oldest pending character.
  always @(posedge clk_i) begin : check_chars
    char_beat_t want;
    if (rst_ni && char_if.valid && char_if.ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character beat bytes=%h len=%0d", $time,
                 char_if.char_bytes, char_if.char_len);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (char_if.char_bytes !== want.bytes) begin
          $display("%0t: char_bytes expected %h actual %h", $time, want.bytes,
                   char_if.char_bytes);
          errors++;
        end
        if (char_if.char_len !== want.len) begin
          $display("%0t: char_len expected %0d actual %0d", $time, want.len,
                   char_if.char_len);
          errors++;
        end
      end
    end
  end

  // Sink side: ready drops in random bursts.
  always @(negedge clk_i) begin : drive_sink_ready
    if (stall_left > 0) begin
      char_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      char_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      char_if.ready <= 1'b1;
    end
  end

  // Present one byte beat, maybe after an idle burst, and wait until it is taken.
  task automatic send_byte(byte_t b, logic start);
    int gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_if.valid        <= 1'b1;
    byte_if.data_byte    <= b;
    byte_if.string_start <= start;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  // A first byte followed by random continuation bytes.
  task automatic send_group(byte_t first, int conts, logic start);
    send_byte(first, start);
    repeat (conts) send_byte(rand_cont(), 1'b0);
  endtask

  // Hold the input idle until every pending character has come out or the drain limit is reached.
  task automatic drain_chars();
    int waited;
    waited = 0;
    @(negedge clk_i);
    byte_if.valid <= 1'b0;
    while (pending_chars.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_chars.size() != 0) begin
      $display("%0t: %0d characters never arrived, next bytes=%h len=%0d", $time,
               pending_chars.size(), pending_chars[0].bytes, pending_chars[0].len);
      errors++;
      pending_chars.delete();
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic test_ascii_bounds();
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
  endtask

  task automatic test_well_formed();
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  // Six-byte character, then continuations that run the count into saturation.
  task automatic test_long_group();
    send_byte(8'hFD, 1'b0);
    send_group(8'hBF, 6, 1'b0);
  endtask

  // 0xFF restarts the group but keeps the length announced by the lead before it.
  task automatic test_reused_length();
    send_byte(8'hC0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // An ASCII byte abandons a pending three-byte character.
  task automatic test_cut_short();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  // A string start drops the pending group, so a continuation that carries the start is stray.
  task automatic test_string_start();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b1);
  endtask

  // Mostly well-formed text with random content, mixed with broken groups and noise.
  task automatic test_random_text();
    int   sent;
    int   kind;
    int   n;
    int   k;
    logic start;
    sent = 0;
    while (sent < RandomItems) begin
      if (sent >= RandomItems - QuietItems) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      kind  = $urandom_range(0, 19);
      start = ($urandom_range(0, 15) == 0);
      if (kind < 12) begin
        n = $urandom_range(1, 6);
        if (n == 1) begin
          send_byte(byte_t'($urandom_range(0, 127)), start);
        end else begin
          send_group(make_lead(n), n - 1, start);
        end
        sent += n;
      end else if (kind < 15) begin
        n = $urandom_range(2, 6);
        k = $urandom_range(0, n - 2);
        send_group(make_lead(n), k, start);
        sent += k + 1;
      end else if (kind < 17) begin
        k = $urandom_range(1, 3);
        send_group(rand_cont(), k - 1, start);
        sent += k;
      end else if (kind == 17) begin
        k = $urandom_range(1, 6);
        send_group(byte_t'($urandom_range(254, 255)), k, start);
        sent += k + 1;
      end else begin
        send_byte(byte_t'($urandom_range(0, 255)), start);
        sent++;
      end
    end
  endtask

  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    byte_if.valid        = 1'b0;
    byte_if.data_byte    = '0;
    byte_if.string_start = 1'b0;
    char_if.ready        = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_ascii_bounds();
    drain_chars();
    test_well_formed();
    drain_chars();
    test_long_group();
    drain_chars();
    test_reused_length();
    drain_chars();
    test_cut_short();
    drain_chars();
    test_string_start();
    drain_chars();
    test_random_text();
    drain_chars();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop in case the core hangs.
  initial begin
    #200000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
